[rtl/core/buzzer_beep_pattern_sequencer_unit_macros.svh]
// Assertion macros for the buzzer beep pattern sequencer checker.
// No dependencies; included by the checker file.
`ifndef BUZZER_BEEP_PATTERN_SEQUENCER_UNIT_MACROS_SVH
`define BUZZER_BEEP_PATTERN_SEQUENCER_UNIT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define BBPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define BBPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/bbps_pkg.sv]
// Package for the buzzer beep pattern sequencer: pattern codes, control state
// type and the per-pattern timing tables. No dependencies.
package bbps_pkg;

  // Default width of the on and off phase timers.
  localparam int unsigned TimerWidthDef = 16;

  // Pattern codes held in the pattern register.
  localparam logic [3:0] PAT_IDLE  = 4'd0;
  localparam logic [3:0] PAT_REP_A = 4'd1;
  localparam logic [3:0] PAT_REP_B = 4'd2;
  localparam logic [3:0] PAT_REP_C = 4'd3;
  localparam logic [3:0] PAT_SGL_A = 4'd4;
  localparam logic [3:0] PAT_SGL_B = 4'd5;
  localparam logic [3:0] PAT_SGL_C = 4'd6;
  localparam logic [3:0] PAT_SGL_D = 4'd7;

  // Narrow control state of the sequencer.
  typedef struct packed {
    logic [3:0] pattern;
    logic       running;
    logic       sounding;
    logic [2:0] beeps_left;
    logic       pin;
  } ctrl_t;

  // Timing of one repeated-beep pattern.
  typedef struct packed {
    logic [2:0] count;
    logic [2:0] len;
    logic [2:0] reload;
  } rep_cfg_t;

  // Beep count, initial phase length and phase reload for repeated beeps.
  function automatic rep_cfg_t rep_cfg(input logic [3:0] code);
    rep_cfg_t cfg;
    case (code)
      PAT_REP_A: cfg = '{count: 3'd5, len: 3'd2, reload: 3'd2};
      PAT_REP_B: cfg = '{count: 3'd3, len: 3'd5, reload: 3'd5};
      PAT_REP_C: cfg = '{count: 3'd5, len: 3'd2, reload: 3'd1};
      default:   cfg = '0;
    endcase
    return cfg;
  endfunction

  // Length in ticks of a single-beep pattern.
  function automatic logic [8:0] single_len(input logic [3:0] code);
    logic [8:0] len;
    case (code)
      PAT_SGL_A: len = 9'd200;
      PAT_SGL_B: len = 9'd10;
      PAT_SGL_C: len = 9'd5;
      PAT_SGL_D: len = 9'd300;
      default:   len = '0;
    endcase
    return len;
  endfunction

endpackage

[rtl/core/bbps_step.sv]
// Next-state logic of the buzzer beep pattern sequencer for one transaction.
// Depends on bbps_pkg.
module bbps_step #(
  parameter int unsigned TimerWidth = bbps_pkg::TimerWidthDef
) (
  input  logic                  command_i,
  input  logic [3:0]            pattern_i,
  input  bbps_pkg::ctrl_t       ctrl_i,
  input  logic [TimerWidth-1:0] on_timer_i,
  input  logic [TimerWidth-1:0] off_timer_i,
  output bbps_pkg::ctrl_t       ctrl_o,
  output logic [TimerWidth-1:0] on_timer_o,
  output logic [TimerWidth-1:0] off_timer_o
);
  import bbps_pkg::*;

  logic [TimerWidth-1:0] on_dec;
  logic [TimerWidth-1:0] off_dec;
  rep_cfg_t              rep;

  // Both timers wrap when decremented from zero.
  assign on_dec  = on_timer_i - TimerWidth'(1);
  assign off_dec = off_timer_i - TimerWidth'(1);
  assign rep     = rep_cfg(ctrl_i.pattern);

  always_comb begin
    ctrl_o      = ctrl_i;
    on_timer_o  = on_timer_i;
    off_timer_o = off_timer_i;
    if (command_i) begin
      // Pattern write: no tick.
      ctrl_o.pattern = pattern_i;
    end else begin
      case (ctrl_i.pattern)
        PAT_IDLE: begin
          ctrl_o      = '0;
          on_timer_o  = '0;
          off_timer_o = '0;
        end
        PAT_REP_A, PAT_REP_B, PAT_REP_C: begin
          if (!ctrl_i.running) begin
            // First tick only loads the pattern timing.
            ctrl_o.beeps_left = rep.count;
            on_timer_o        = TimerWidth'(rep.len);
            off_timer_o       = TimerWidth'(rep.len);
            ctrl_o.running    = 1'b1;
          end else if (ctrl_i.beeps_left == 3'd0) begin
            ctrl_o      = '0;
            on_timer_o  = '0;
            off_timer_o = '0;
          end else if (ctrl_i.sounding) begin
            // On phase: the count drops when it ends.
            if (on_dec != '0) begin
              on_timer_o = on_dec;
              ctrl_o.pin = 1'b1;
            end else begin
              ctrl_o.sounding   = 1'b0;
              on_timer_o        = TimerWidth'(rep.reload);
              ctrl_o.beeps_left = ctrl_i.beeps_left - 3'd1;
            end
          end else begin
            // Off phase.
            if (off_dec != '0) begin
              off_timer_o = off_dec;
              ctrl_o.pin  = 1'b0;
            end else begin
              ctrl_o.sounding = 1'b1;
              off_timer_o     = TimerWidth'(rep.reload);
            end
          end
        end
        PAT_SGL_A, PAT_SGL_B, PAT_SGL_C, PAT_SGL_D: begin
          if (!ctrl_i.running) begin
            on_timer_o     = TimerWidth'(single_len(ctrl_i.pattern));
            ctrl_o.pin     = 1'b1;
            ctrl_o.running = 1'b1;
          end else if (on_dec == '0) begin
            ctrl_o      = '0;
            on_timer_o  = '0;
            off_timer_o = '0;
          end else begin
            on_timer_o = on_dec;
            ctrl_o.pin = 1'b1;
          end
        end
        default: begin
          // Undefined codes silence the pin and drop the pattern only.
          ctrl_o.pin     = 1'b0;
          ctrl_o.pattern = PAT_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/buzzer_beep_pattern_sequencer_unit.sv]
// Top level of the buzzer beep pattern sequencer: state registers and the
// valid/ready handshakes. Depends on bbps_pkg and bbps_step.
//
// Each input transaction is either a pattern write or one timer tick, and
// produces exactly one result: the buzzer drive, the busy flag and the pattern
// register as they stand after that transaction. A transaction is accepted in
// every cycle in which the previous result has been taken or is taken in the
// same cycle; its result is presented in the cycle after acceptance. This
// follows from the state registers, which are updated from the current state
// by one pass of next-state logic and also serve as the output register.
// After reset the buzzer is silent and the pattern register reads idle.
module buzzer_beep_pattern_sequencer_unit #(
  parameter int unsigned TimerWidth = bbps_pkg::TimerWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       command_i,
  input  logic [3:0] pattern_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       sound_o,
  output logic       busy_res_o,
  output logic [3:0] active_pattern_o
);
  import bbps_pkg::*;

  ctrl_t                 ctrl_q, ctrl_d;
  logic [TimerWidth-1:0] on_timer_q, on_timer_d;
  logic [TimerWidth-1:0] off_timer_q, off_timer_d;
  logic                  out_valid_q;
  logic                  accept;

  // A new transaction enters when the result slot is free or draining.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  bbps_step #(
    .TimerWidth(TimerWidth)
  ) u_step (
    .command_i  (command_i),
    .pattern_i  (pattern_i),
    .ctrl_i     (ctrl_q),
    .on_timer_i (on_timer_q),
    .off_timer_i(off_timer_q),
    .ctrl_o     (ctrl_d),
    .on_timer_o (on_timer_d),
    .off_timer_o(off_timer_d)
  );

  // State advances only on an accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q      <= '0;
      on_timer_q  <= '0;
      off_timer_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        ctrl_q      <= ctrl_d;
        on_timer_q  <= on_timer_d;
        off_timer_q <= off_timer_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The state after the last transaction is the result.
  assign out_valid_o      = out_valid_q;
  assign sound_o          = ctrl_q.pin;
  assign busy_res_o       = ctrl_q.running;
  assign active_pattern_o = ctrl_q.pattern;

endmodule

[rtl/core/bbps_checker.sv]
// Port-level checker for the buzzer beep pattern sequencer, bound to the top.
// Depends on buzzer_beep_pattern_sequencer_unit_macros.svh.
`include "buzzer_beep_pattern_sequencer_unit_macros.svh"

module bbps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       command_i,
  input logic [3:0] pattern_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       sound_o,
  input logic       busy_res_o,
  input logic [3:0] active_pattern_o
);

  // A stalled result holds its payload.
  `BBPS_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(sound_o) && $stable(busy_res_o) && $stable(active_pattern_o)), "stalled result changed")

  // The buzzer never sounds while no pattern is running.
  `BBPS_ASSERT(a_silent_idle, clk_i, rst_ni, (out_valid_o && !busy_res_o) |-> !sound_o, "buzzer on while not busy")

  // A pattern write shows up unchanged in the next result, whatever the code.
  `BBPS_ASSERT(a_write_seen, clk_i, rst_ni, (in_valid_i && in_ready_o && command_i) |=> (out_valid_o && (active_pattern_o == $past(pattern_i))), "pattern write not reflected")

  // With no result pending the input side is open.
  `BBPS_ASSERT(a_ready_free, clk_i, rst_ni, !out_valid_o |-> in_ready_o, "input stalled with empty output")

  // No result is offered during reset.
  `BBPS_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind buzzer_beep_pattern_sequencer_unit bbps_checker u_bbps_checker (.*);
